// File: hw/rtl/scta_pkg.sv
// Shared types, key codes and the set-1 key table for the scan code to ASCII buffer.
// No dependencies; every other file imports this package.
`default_nettype none

package scta_pkg;

  localparam int unsigned RingDepth = 16;

  localparam logic [7:0] KeyEsc    = 8'h01;
  localparam logic [7:0] KeyCtrl   = 8'h1D;
  localparam logic [7:0] KeyLShift = 8'h2A;
  localparam logic [7:0] KeyRShift = 8'h36;
  localparam logic [7:0] KeyAlt    = 8'h38;
  localparam logic [7:0] KeyCaps   = 8'h3A;
  localparam logic [7:0] BreakBit  = 8'h80;
  localparam logic [7:0] MapKeys   = 8'd59;

  localparam logic [6:0] CharLowA = 7'h61;
  localparam logic [6:0] CharLowZ = 7'h7A;
  localparam logic [6:0] CharLowS = 7'h73;

  typedef enum logic {
    OP_SCAN = 1'b0,
    OP_READ = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_READ,
    CMD_STORE,
    CMD_SNAP
  } cmd_e;

  typedef struct packed {
    logic       opcode;
    logic [7:0] key_code;
  } in_t;

  typedef struct packed {
    logic [6:0] read_char;
    logic       read_valid;
    logic       char_stored;
    logic       snapshot_request;
  } out_t;

  typedef struct packed {
    cmd_e       kind;
    logic [6:0] ch;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  // {plain, shifted} for make codes below MapKeys; zero means no character
  function automatic logic [13:0] key_map(input logic [5:0] code);
    logic [13:0] e;
    case (code)
      6'd2:    e = {7'h31, 7'h21};
      6'd3:    e = {7'h32, 7'h40};
      6'd4:    e = {7'h33, 7'h23};
      6'd5:    e = {7'h34, 7'h24};
      6'd6:    e = {7'h35, 7'h25};
      6'd7:    e = {7'h36, 7'h5E};
      6'd8:    e = {7'h37, 7'h26};
      6'd9:    e = {7'h38, 7'h2A};
      6'd10:   e = {7'h39, 7'h28};
      6'd11:   e = {7'h30, 7'h29};
      6'd12:   e = {7'h2D, 7'h5F};
      6'd13:   e = {7'h3D, 7'h2B};
      6'd14:   e = {7'h08, 7'h08};
      6'd15:   e = {7'h09, 7'h09};
      6'd16:   e = {7'h71, 7'h51};
      6'd17:   e = {7'h77, 7'h57};
      6'd18:   e = {7'h65, 7'h45};
      6'd19:   e = {7'h72, 7'h52};
      6'd20:   e = {7'h74, 7'h54};
      6'd21:   e = {7'h79, 7'h59};
      6'd22:   e = {7'h75, 7'h55};
      6'd23:   e = {7'h69, 7'h49};
      6'd24:   e = {7'h6F, 7'h4F};
      6'd25:   e = {7'h70, 7'h50};
      6'd26:   e = {7'h5B, 7'h7B};
      6'd27:   e = {7'h5D, 7'h7D};
      6'd28:   e = {7'h0A, 7'h0A};
      6'd30:   e = {7'h61, 7'h41};
      6'd31:   e = {7'h73, 7'h53};
      6'd32:   e = {7'h64, 7'h44};
      6'd33:   e = {7'h66, 7'h46};
      6'd34:   e = {7'h67, 7'h47};
      6'd35:   e = {7'h68, 7'h48};
      6'd36:   e = {7'h6A, 7'h4A};
      6'd37:   e = {7'h6B, 7'h4B};
      6'd38:   e = {7'h6C, 7'h4C};
      6'd39:   e = {7'h3B, 7'h3A};
      6'd40:   e = {7'h27, 7'h22};
      6'd41:   e = {7'h60, 7'h7E};
      6'd43:   e = {7'h5C, 7'h7C};
      6'd44:   e = {7'h7A, 7'h5A};
      6'd45:   e = {7'h78, 7'h58};
      6'd46:   e = {7'h63, 7'h43};
      6'd47:   e = {7'h76, 7'h56};
      6'd48:   e = {7'h62, 7'h42};
      6'd49:   e = {7'h6E, 7'h4E};
      6'd50:   e = {7'h6D, 7'h4D};
      6'd51:   e = {7'h2C, 7'h3C};
      6'd52:   e = {7'h2E, 7'h3E};
      6'd53:   e = {7'h2F, 7'h3F};
      6'd57:   e = {7'h20, 7'h20};
      default: e = 14'd0;
    endcase
    return e;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/scta_front.sv
// Front end: accepts beats, tracks shift/caps/ctrl and turns each beat into a command.
// Depends on scta_pkg.
`default_nettype none

module scta_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  input  wire scta_pkg::in_t  in_data_i,
  output logic                in_stall_o,
  input  wire scta_pkg::qstat_t qstat_i,
  output logic                push_o,
  output scta_pkg::cmd_t      cmd_o
);
  import scta_pkg::*;

  logic        shift_q, shift_d;
  logic        caps_q, caps_d;
  logic        ctrl_q, ctrl_d;
  logic [7:0]  code;
  logic        is_mod;
  logic        mapped;
  logic [13:0] entry;
  logic [6:0]  plain, shifted, ch;
  logic        col;

  assign in_stall_o = qstat_i.full;
  assign push_o     = in_valid_i && !qstat_i.full;
  assign code       = in_data_i.key_code;

  always_comb begin
    shift_d = shift_q;
    caps_d  = caps_q;
    ctrl_d  = ctrl_q;
    if (in_data_i.opcode == OP_SCAN) begin
      if (code == KeyLShift || code == KeyRShift) begin
        shift_d = 1'b1;
      end else if (code == (KeyLShift | BreakBit) || code == (KeyRShift | BreakBit)) begin
        shift_d = 1'b0;
      end else if (code == KeyCaps) begin
        caps_d = !caps_q;
      end else if (code == KeyCtrl) begin
        ctrl_d = 1'b1;
      end else if (code == (KeyCtrl | BreakBit)) begin
        ctrl_d = 1'b0;
      end
    end
  end

  assign is_mod = (code == KeyEsc) || (code == KeyCtrl) || (code == KeyLShift) ||
                  (code == KeyRShift) || (code == KeyAlt) || (code == KeyCaps);
  assign mapped = (code < MapKeys) && !is_mod;

  assign entry   = key_map(code[5:0]);
  assign plain   = entry[13:7];
  assign shifted = entry[6:0];
  // caps flips the column for letters only; modifier codes are kept out by mapped
  assign col     = (plain >= CharLowA && plain <= CharLowZ) ? (caps_q ^ shift_q) : shift_q;
  assign ch      = col ? shifted : plain;

  always_comb begin
    cmd_o.ch   = ch;
    cmd_o.kind = CMD_NONE;
    if (in_data_i.opcode == OP_READ) begin
      cmd_o.kind = CMD_READ;
    end else if (mapped) begin
      if (ctrl_q) begin
        if (ch == CharLowS) cmd_o.kind = CMD_SNAP;
      end else if (ch != 7'd0) begin
        cmd_o.kind = CMD_STORE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= 1'b0;
      caps_q  <= 1'b0;
      ctrl_q  <= 1'b0;
    end else if (push_o) begin
      shift_q <= shift_d;
      caps_q  <= caps_d;
      ctrl_q  <= ctrl_d;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/scta_queue.sv
// Two-entry command queue between the front end and the ring back end.
// Depends on scta_pkg.
`default_nettype none

module scta_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire scta_pkg::cmd_t   cmd_i,
  input  wire logic             pop_i,
  output scta_pkg::cmd_t        cmd_o,
  output scta_pkg::qstat_t      qstat_o
);
  import scta_pkg::*;

  cmd_t       slot_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign cmd_o         = slot_q[rd_q];
  assign qstat_o.full  = (cnt_q == 2'd2);
  assign qstat_o.empty = (cnt_q == 2'd0);

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop_i)  rd_q <= !rd_q;
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/scta_back.sv
// Back end: executes commands against the character ring and holds the result register.
// Depends on scta_pkg.
`default_nettype none

module scta_back #(
  parameter int unsigned RING_DEPTH = scta_pkg::RingDepth
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cmd_valid_i,
  input  wire scta_pkg::cmd_t   cmd_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output scta_pkg::out_t        out_data_o
);
  import scta_pkg::*;

  localparam int unsigned PtrW = $clog2(RING_DEPTH);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(RING_DEPTH - 1);

  logic [6:0]           ring_mem [RING_DEPTH];
  logic [RING_DEPTH-1:0] full_q;
  logic [PtrW-1:0]      wr_q, rd_q;
  logic                 out_valid_q;
  out_t                 out_q;
  logic                 is_read, is_store, hit;

  assign pop_o    = cmd_valid_i && (!out_valid_q || !out_stall_i);
  assign is_read  = (cmd_i.kind == CMD_READ);
  assign is_store = (cmd_i.kind == CMD_STORE);
  assign hit      = is_read && full_q[rd_q];

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i) begin
    if (pop_o && is_store) ring_mem[wr_q] <= cmd_i.ch;
    if (pop_o) begin
      out_q.read_char        <= hit ? ring_mem[rd_q] : 7'd0;
      out_q.read_valid       <= hit;
      out_q.char_stored      <= is_store;
      out_q.snapshot_request <= (cmd_i.kind == CMD_SNAP);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q      <= '0;
      wr_q        <= '0;
      rd_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      // a store into a full ring overwrites; the read pointer stays put
      if (pop_o && is_store) begin
        full_q[wr_q] <= 1'b1;
        wr_q         <= (wr_q == PtrLast) ? '0 : wr_q + 1'b1;
      end
      if (pop_o && hit) begin
        full_q[rd_q] <= 1'b0;
        rd_q         <= (rd_q == PtrLast) ? '0 : rd_q + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/scan_code_to_ascii_buffer_top.sv
// Top level of the scan code to ASCII buffer: front end, command queue, ring back end.
// Depends on scta_pkg, scta_front, scta_queue, scta_back.
`default_nettype none

// Takes one beat per cycle while in_stall_o is low: a set-1 scan code
// (opcode 0) or a read of one buffered character (opcode 1), and returns
// exactly one result beat for each. Sustained rate is one beat per clock
// while out_stall_i is low. A beat is first written into the two-entry
// command queue, then the back end pops it and loads the output register
// that drives out_data_o. in_stall_o rises only when that queue is full, which
// happens only while out_stall_i holds results back. Shift, caps and ctrl
// state lives in the front end; the RING_DEPTH-entry character ring, its
// per-entry occupancy bits and both pointers live in the back end. Reset
// empties the ring at once, with no clearing pass.
module scan_code_to_ascii_buffer_top #(
  parameter int unsigned RING_DEPTH = scta_pkg::RingDepth
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire scta_pkg::in_t  in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output scta_pkg::out_t      out_data_o
);
  import scta_pkg::*;

  logic   push, pop;
  cmd_t   push_cmd, pop_cmd;
  qstat_t qstat;

  scta_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_stall_o (in_stall_o),
    .qstat_i    (qstat),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  scta_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (pop),
    .cmd_o   (pop_cmd),
    .qstat_o (qstat)
  );

  scta_back #(
    .RING_DEPTH (RING_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!qstat.empty),
    .cmd_i       (pop_cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  a_char_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.read_valid == (out_data_o.read_char != 7'd0)))
    else $error("read_char and read_valid disagree");

  a_one_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.read_valid && out_data_o.char_stored) &&
                    !(out_data_o.read_valid && out_data_o.snapshot_request) &&
                    !(out_data_o.char_stored && out_data_o.snapshot_request))
    else $error("result beat carries more than one kind");

  a_result_from_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!qstat.empty))
    else $error("result produced with an empty command queue");

endmodule

`default_nettype wire

// File: tb/sv/scan_code_to_ascii_buffer_checker.sv
// Checker for the scan code to ASCII buffer: watches both channels, predicts each result
// from its own key table, modifier flags and character ring, and counts mismatches.
// Depends on scta_pkg.
`timescale 1ns / 100ps

module scan_code_to_ascii_buffer_checker (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  input  wire logic           in_stall_i,
  input  wire scta_pkg::in_t  in_data_i,
  input  wire logic           out_valid_i,
  input  wire logic           out_stall_i,
  input  wire scta_pkg::out_t out_data_i,
  output int unsigned         mismatch_count_o,
  output int unsigned         pending_o,
  output int unsigned         beats_o,
  output int unsigned         stored_o,
  output int unsigned         popped_o,
  output int unsigned         snapshots_o
);
  import scta_pkg::*;

  localparam int unsigned PosW = $clog2(RingDepth);

  logic            shift_held;
  logic            caps_on;
  logic            ctrl_held;
  logic [6:0]      ring_chars [RingDepth];
  logic [PosW-1:0] wr_pos;
  logic [PosW-1:0] rd_pos;
  out_t            pending_results [$];

  // {plain, shifted} ASCII for a set-1 make code, zero where the key has no character
  function automatic logic [15:0] set1_chars(input logic [7:0] code);
    case (code)
      8'd2:    return "1!";
      8'd3:    return "2@";
      8'd4:    return "3#";
      8'd5:    return "4$";
      8'd6:    return "5%";
      8'd7:    return "6^";
      8'd8:    return "7&";
      8'd9:    return "8*";
      8'd10:   return "9(";
      8'd11:   return "0)";
      8'd12:   return "-_";
      8'd13:   return "=+";
      8'd14:   return 16'h0808;
      8'd15:   return 16'h0909;
      8'd16:   return "qQ";
      8'd17:   return "wW";
      8'd18:   return "eE";
      8'd19:   return "rR";
      8'd20:   return "tT";
      8'd21:   return "yY";
      8'd22:   return "uU";
      8'd23:   return "iI";
      8'd24:   return "oO";
      8'd25:   return "pP";
      8'd26:   return "[{";
      8'd27:   return "]}";
      8'd28:   return 16'h0A0A;
      8'd30:   return "aA";
      8'd31:   return "sS";
      8'd32:   return "dD";
      8'd33:   return "fF";
      8'd34:   return "gG";
      8'd35:   return "hH";
      8'd36:   return "jJ";
      8'd37:   return "kK";
      8'd38:   return "lL";
      8'd39:   return ";:";
      8'd40:   return 16'h2722;
      8'd41:   return 16'h607E;
      8'd43:   return 16'h5C7C;
      8'd44:   return "zZ";
      8'd45:   return "xX";
      8'd46:   return "cC";
      8'd47:   return "vV";
      8'd48:   return "bB";
      8'd49:   return "nN";
      8'd50:   return "mM";
      8'd51:   return ",<";
      8'd52:   return ".>";
      8'd53:   return "/?";
      8'd57:   return 16'h2020;
      default: return 16'h0000;
    endcase
  endfunction

  // Applies one input beat to the modeled state and returns the result it must produce
  function automatic out_t predict_key_beat(input in_t beat);
    out_t        res;
    logic [7:0]  code;
    logic [15:0] pair;
    logic [7:0]  ch;
    logic        col;
    logic        modifier;
    res      = '0;
    code     = beat.key_code;
    modifier = 1'b0;
    if (beat.opcode == OP_READ) begin
      if (ring_chars[rd_pos] != '0) begin
        res.read_char        = ring_chars[rd_pos];
        res.read_valid       = 1'b1;
        ring_chars[rd_pos]   = '0;
        rd_pos               = PosW'((rd_pos + 1) % RingDepth);
      end
    end else begin
      case (code)
        KeyLShift, KeyRShift: begin
          shift_held = 1'b1;
          modifier   = 1'b1;
        end
        KeyLShift | BreakBit, KeyRShift | BreakBit: shift_held = 1'b0;
        KeyCaps: begin
          caps_on  = ~caps_on;
          modifier = 1'b1;
        end
        KeyCtrl: begin
          ctrl_held = 1'b1;
          modifier  = 1'b1;
        end
        KeyCtrl | BreakBit: ctrl_held = 1'b0;
        KeyEsc, KeyAlt: modifier = 1'b1;
        default: ;
      endcase
      if (code < MapKeys && !modifier) begin
        pair = set1_chars(code);
        col  = shift_held;
        // caps lock flips the column for letters only
        if (pair[15:8] >= CharLowA && pair[15:8] <= CharLowZ) col = shift_held ^ caps_on;
        ch = col ? pair[7:0] : pair[15:8];
        if (ctrl_held) begin
          res.snapshot_request = (ch == {1'b0, CharLowS});
        end else if (ch != '0) begin
          ring_chars[wr_pos] = ch[6:0];
          wr_pos             = PosW'((wr_pos + 1) % RingDepth);
          res.char_stored    = 1'b1;
        end
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("[%0t] mismatch at result %0d: %s got 0x%0h, expected 0x%0h",
             $time, beats_o, what, got, want);
    mismatch_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    out_t got;
    if (!rst_ni) begin
      shift_held = 1'b0;
      caps_on    = 1'b0;
      ctrl_held  = 1'b0;
      wr_pos     = '0;
      rd_pos     = '0;
      for (int i = 0; i < RingDepth; i++) ring_chars[i] = '0;
      pending_results.delete();
      mismatch_count_o = 0;
      pending_o        = 0;
      beats_o          = 0;
      stored_o         = 0;
      popped_o         = 0;
      snapshots_o      = 0;
    end else begin
      // result beats first: a result can never belong to the input taken at this edge
      if (out_valid_i && !out_stall_i) begin
        got = out_data_i;
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing pending", 8'(got), 8'h00);
        end else begin
          want = pending_results.pop_front();
          if (got.read_char !== want.read_char)
            report_mismatch("read_char", 8'(got.read_char), 8'(want.read_char));
          if (got.read_valid !== want.read_valid)
            report_mismatch("read_valid", 8'(got.read_valid), 8'(want.read_valid));
          if (got.char_stored !== want.char_stored)
            report_mismatch("char_stored", 8'(got.char_stored), 8'(want.char_stored));
          if (got.snapshot_request !== want.snapshot_request)
            report_mismatch("snapshot_request", 8'(got.snapshot_request),
                            8'(want.snapshot_request));
        end
        beats_o++;
      end
      if (in_valid_i && !in_stall_i) begin
        want = predict_key_beat(in_data_i);
        stored_o    += want.char_stored;
        popped_o    += want.read_valid;
        snapshots_o += want.snapshot_request;
        pending_results.push_back(want);
      end
      pending_o = pending_results.size();
    end
  end

endmodule

// File: tb/sv/scan_code_to_ascii_buffer_top_tb.sv
// Testbench top for scan_code_to_ascii_buffer_top: clock, reset, directed and random
// key beats with random idling on both channels, and the final verdict.
// Depends on scta_pkg, the block's RTL and scan_code_to_ascii_buffer_checker.
`timescale 1ns / 100ps

module scan_code_to_ascii_buffer_top_tb;
  import scta_pkg::*;

  localparam logic [7:0] KeyS = 8'h1F;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  in_t  in_data   = '0;
  logic out_stall = 1'b0;
  logic in_stall;
  logic out_valid;
  out_t out_data;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  int unsigned mismatch_count;
  int unsigned pending;
  int unsigned beats;
  int unsigned stored;
  int unsigned popped;
  int unsigned snapshots;

  scan_code_to_ascii_buffer_top dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  scan_code_to_ascii_buffer_checker check_u (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .in_data_i       (in_data),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .out_data_i      (out_data),
    .mismatch_count_o(mismatch_count),
    .pending_o       (pending),
    .beats_o         (beats),
    .stored_o        (stored),
    .popped_o        (popped),
    .snapshots_o     (snapshots)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Starts and ends on a falling edge; valid stays high into the next beat unless it idles
  task automatic send_beat(input op_e op, input logic [7:0] code);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_data.opcode   <= op;
    in_data.key_code <= code;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic send_scan(input logic [7:0] code);
    send_beat(OP_SCAN, code);
  endtask

  task automatic send_random_keys(input int unsigned count, input int unsigned read_pct);
    int unsigned pick;
    logic [7:0]  code;
    repeat (count) begin
      if ($urandom_range(99) < read_pct) begin
        send_beat(OP_READ, 8'($urandom));
      end else begin
        pick = $urandom_range(99);
        if (pick < 62) begin
          // lean on the s key so ctrl held gives snapshot requests
          code = ($urandom_range(4) == 0) ? KeyS : 8'($urandom_range(MapKeys - 1));
        end else if (pick < 80) begin
          case ($urandom_range(9))
            0:       code = KeyLShift;
            1:       code = KeyLShift | BreakBit;
            2:       code = KeyRShift;
            3:       code = KeyRShift | BreakBit;
            4:       code = KeyCaps;
            5:       code = KeyCtrl;
            6, 7:    code = KeyCtrl | BreakBit;
            8:       code = KeyEsc;
            default: code = KeyAlt;
          endcase
        end else if (pick < 88) begin
          code = 8'($urandom_range(127, MapKeys));
        end else if (pick < 95) begin
          code = 8'($urandom_range(255, 128));
        end else begin
          code = 8'($urandom);
        end
        send_scan(code);
      end
    end
  endtask

  initial begin
    send_idle_pct  = 7;
    recv_stall_pct = 52;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty read, dead table entries, modifiers, caps, ctrl, ignored codes
    send_beat(OP_READ, 8'hFF);
    send_scan(8'h00);
    send_scan(KeyEsc);
    send_scan(KeyAlt);
    send_scan(8'd2);
    send_scan(8'd16);
    send_scan(KeyLShift);
    send_scan(8'd2);
    send_scan(8'd16);
    send_scan(KeyLShift | BreakBit);
    send_scan(KeyCaps);
    send_scan(8'd16);
    send_scan(8'd2);
    send_scan(KeyRShift);
    send_scan(8'd16);
    send_scan(KeyRShift | BreakBit);
    send_scan(KeyCaps);
    send_scan(KeyCtrl);
    send_scan(KeyS);
    send_scan(8'd30);
    send_scan(KeyCtrl | BreakBit);
    send_scan(MapKeys);
    send_scan(8'h7F);
    send_scan(8'h80);
    send_scan(8'd57);
    repeat (3) send_beat(OP_READ, 8'h00);

    send_random_keys(140, 15);
    drain_results();

    send_idle_pct  = 52;
    recv_stall_pct = 7;
    send_random_keys(140, 50);
    drain_results();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_random_keys(140, 35);
    drain_results();
    repeat (6) @(posedge clk);

    $display("Covered %0d beats: %0d characters stored, %0d popped by reads,", beats, stored,
             popped);
    $display("%0d snapshot requests, across modifier, caps, ctrl and ring wrap cases.",
             snapshots);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d results still pending", pending);
    $display("FAILED: results differ");
    $finish;
  end

endmodule
